FILE: sv/cfl_pkg.sv
// ----------------------------------------------------------------------------
// cfl_pkg: shared types and constants of the connection flood limiter
// Entry count, field widths, verdict codes, register indexes and the structs
// that the cell chain passes along.
// ----------------------------------------------------------------------------
package cfl_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    localparam int KEY_W   = 64;
    localparam int TICK_W  = 64;
    localparam int HITS_W  = 16;
    localparam int CFG_W   = 15;
    localparam int CFG_IDX_W = 1;

    localparam logic [HITS_W-1:0] HITS_MAX    = '1;
    localparam logic [KEY_W-1:0]  V4_MAP_MARK = 64'h0000_FFFF_0000_0000;

    typedef enum logic [1:0] {
        VERD_ACCEPT = 2'd0,
        VERD_FLOOD  = 2'd1,
        VERD_FULL   = 2'd2
    } t_verdict;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HIT_LIMIT = 1'b0,
        REG_WINDOW    = 1'b1
    } t_cfg_reg;

    // search state handed from cell to cell
    typedef struct packed {
        logic              act;
        logic              found;
        logic [HITS_W-1:0] hits;
        logic              free_ok;
        logic [IDX_W-1:0]  free_idx;
    } t_tok;

    // lookup key and time, held for the whole pass
    typedef struct packed {
        logic [KEY_W-1:0]  khi;
        logic [KEY_W-1:0]  klo;
        logic [TICK_W-1:0] now;
        logic [CFG_W-1:0]  window;
    } t_query;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } t_ins;

endpackage

FILE: sv/cfl_cell.sv
// ----------------------------------------------------------------------------
// cfl_cell: one table entry of the connection flood limiter
// Holds key, first-seen tick and hit count of one source. When the search
// beat passes, it frees the entry on expiry, counts a hit on the first match
// and reports itself if it is the first free slot; then forwards the beat.
// ----------------------------------------------------------------------------
module cfl_cell import cfl_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_cell_idx,
    input  t_query           i_query,
    input  t_ins             i_ins,
    input  t_tok             i_tok,
    output t_tok             o_tok
);

    logic              r_valid;
    logic [KEY_W-1:0]  r_khi;
    logic [KEY_W-1:0]  r_klo;
    logic [TICK_W-1:0] r_seen;
    logic [HITS_W-1:0] r_hits;
    t_tok              r_tok;
    t_tok              n_tok;

    logic [TICK_W:0]   w_deadline;
    logic              w_expired;
    logic              w_live;
    logic              w_match;
    logic              w_write;
    logic              w_count;
    logic [HITS_W-1:0] w_hits_inc;

    // no wrap: the deadline is one bit wider than the tick
    assign w_deadline = {1'b0, r_seen} + {{(TICK_W + 1 - CFG_W){1'b0}}, i_query.window};
    assign w_expired  = r_valid && (w_deadline < {1'b0, i_query.now});
    assign w_live     = r_valid && !w_expired;
    assign w_match    = w_live && (r_khi == i_query.khi) && (r_klo == i_query.klo);
    assign w_hits_inc = (r_hits == HITS_MAX) ? r_hits : r_hits + 1'b1;
    assign w_write    = i_ins.en && (i_ins.idx == i_cell_idx);
    assign w_count    = i_tok.act && w_match && !i_tok.found;

    always_comb begin
        n_tok = i_tok;
        if (w_count) begin
            n_tok.found = 1'b1;
            n_tok.hits  = w_hits_inc;
        end
        if (i_tok.act && !w_live && !i_tok.free_ok) begin
            n_tok.free_ok  = 1'b1;
            n_tok.free_idx = i_cell_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_tok.act <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (w_write) begin
                r_valid <= 1'b1;
            end else if (i_tok.act && w_expired) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_khi  <= i_query.khi;
            r_klo  <= i_query.klo;
            r_seen <= i_query.now;
            r_hits <= HITS_W'(1);
        end else if (w_count) begin
            r_hits <= w_hits_inc;
        end
    end

    assign o_tok = r_tok;

endmodule

FILE: sv/connection_flood_limiter.sv
// ----------------------------------------------------------------------------
// connection_flood_limiter: per-source fixed-window connection rate limiter
// A search beat walks a row of TABLE_ENTRIES cells, one cell a cycle; the
// controller turns the beat that leaves the row into a verdict and a write
// of a new entry.
//
//   channel   dir  beat contents (low bits first)
//   s         in   tuser: is_v6; tdata: addr_upper, addr_lower, now_tick
//   m         out  tuser: verdict; tdata: hit_count
//   cfg       in   idx 0 hit_limit, idx 1 window_ticks (15 bit data)
//
// from accept to result an event passes the start register, the cell row, the
// pending result and the output register; one event is in flight.
// the next event is taken while the previous result still waits on m.
// reset clears all entry valid bits at once, no clearing pass.
// ----------------------------------------------------------------------------
module connection_flood_limiter import cfl_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [191:0]           i_s_tdata,   // addr_upper, addr_lower, now_tick
    input  logic                   i_s_tuser,   // is_v6
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [HITS_W-1:0]      o_m_tdata,   // hit_count
    output logic [1:0]             o_m_tuser,   // verdict
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    t_state            r_state;
    logic              r_start;
    logic [KEY_W-1:0]  r_khi;
    logic [KEY_W-1:0]  r_klo;
    logic [TICK_W-1:0] r_now;
    logic [CFG_W-1:0]  r_hit_limit;
    logic [CFG_W-1:0]  r_window;
    t_verdict          r_pend_verdict;
    logic [HITS_W-1:0] r_pend_hits;
    logic              r_pend_ins;
    logic [IDX_W-1:0]  r_pend_idx;
    logic              r_m_valid;
    t_verdict          r_m_verdict;
    logic [HITS_W-1:0] r_m_hits;
    t_ins              r_ins;

    t_tok              w_tok [0:TABLE_ENTRIES];
    t_tok              w_end;
    t_query            w_query;
    logic              w_s_acc;
    logic              w_out_free;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_s_acc    = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_m_valid || i_m_tready;

    assign w_query = '{khi: r_khi, klo: r_klo, now: r_now, window: r_window};
    assign w_tok[0] = '{act: r_start, found: 1'b0, hits: '0, free_ok: 1'b0, free_idx: '0};
    assign w_end = w_tok[TABLE_ENTRIES];

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        cfl_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (IDX_W'(g)),
            .i_query    (w_query),
            .i_ins      (r_ins),
            .i_tok      (w_tok[g]),
            .o_tok      (w_tok[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_limit <= '0;
            r_window    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_HIT_LIMIT: r_hit_limit <= i_cfg_data;
                REG_WINDOW:    r_window    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // key and time of the event in flight
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_now <= i_s_tdata[191:128];
            if (i_s_tuser) begin
                r_khi <= i_s_tdata[63:0];
                r_klo <= i_s_tdata[127:64];
            end else begin
                r_khi <= '0;
                r_klo <= V4_MAP_MARK | {32'd0, i_s_tdata[95:64]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_start   <= 1'b0;
            r_m_valid <= 1'b0;
            r_ins.en  <= 1'b0;
        end else begin
            r_start  <= w_s_acc;
            r_ins.en <= (r_state == ST_DONE) && w_out_free && r_pend_ins;
            if (r_m_valid && i_m_tready && r_state != ST_DONE) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_s_acc) begin
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (w_end.act) begin
                        r_pend_idx <= w_end.free_idx;
                        r_pend_ins <= 1'b0;
                        if (w_end.found) begin
                            r_pend_hits    <= w_end.hits;
                            r_pend_verdict <= (w_end.hits > {1'b0, r_hit_limit})
                                              ? VERD_FLOOD : VERD_ACCEPT;
                        end else if (w_end.free_ok) begin
                            r_pend_hits    <= HITS_W'(1);
                            r_pend_verdict <= VERD_ACCEPT;
                            r_pend_ins     <= 1'b1;
                        end else begin
                            r_pend_hits    <= '0;
                            r_pend_verdict <= VERD_FULL;
                        end
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_m_valid   <= 1'b1;
                        r_m_verdict <= r_pend_verdict;
                        r_m_hits    <= r_pend_hits;
                        r_ins.idx   <= r_pend_idx;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_hits;
    assign o_m_tuser  = r_m_verdict;

    // the search beat leaves the row only while the controller waits for it
    a_end_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_end.act |-> r_state == ST_SCAN)
        else $error("search beat left the cell row outside a scan");

    a_start_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc |=> r_start && r_state == ST_SCAN)
        else $error("accepted event did not start a scan");

    a_insert_not_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ins.en |-> !w_tok[0].act && r_state != ST_SCAN)
        else $error("entry write overlaps a scan");

    a_full_has_no_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid && r_m_verdict == VERD_FULL |-> r_m_hits == '0)
        else $error("table full verdict with nonzero hit count");

    a_accept_has_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid && r_m_verdict == VERD_ACCEPT |-> r_m_hits != '0)
        else $error("accept verdict with zero hit count");

endmodule
